@@ rtl/core/pdm_to_pcm_decimator_macros.svh @@
// Assertion macros for the PDM to PCM decimator.
// Used by the top level; relies on clock and reset being in scope.
`ifndef PDM_TO_PCM_DECIMATOR_MACROS_SVH
`define PDM_TO_PCM_DECIMATOR_MACROS_SVH

// same-cycle implication
`define PDMDEC_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PDMDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/pdmdec_pkg.sv @@
// Shared constants, types and the FIR coefficient table of the decimator.
// No dependencies.
`default_nettype none

package pdmdec_pkg;

   localparam int ByteW      = 8;
   localparam int CntW       = 7;
   localparam int Decimation = 64;
   localparam int IntW       = 20;
   localparam int CombShift  = 3;
   localparam int SampW      = IntW - CombShift;
   localparam int Taps       = 16;
   localparam int TapIdxW    = 4;
   localparam int CoefW      = 14;
   localparam int ProdShift  = 15;
   localparam int ProdW      = SampW + CoefW;
   localparam int TermW      = ProdW - ProdShift;
   localparam int AccW       = 20;
   localparam int PcmW       = 16;

   localparam logic signed [AccW-1:0] PcmMax = AccW'(32767);
   localparam logic signed [AccW-1:0] PcmMin = -AccW'(32768);

   typedef struct packed {
      logic done;   // byte fully integrated
      logic hit;    // a decimation period closed on this byte
   } cic_status_type;

   typedef struct packed {
      logic busy;
      logic done;
   } fir_status_type;

   // Q15 low-pass taps, newest sample first
   function automatic logic signed [CoefW-1:0] fir_coef(input logic [TapIdxW-1:0] idx);
      logic signed [CoefW-1:0] c;
      case (idx)
         4'd0, 4'd15:  c = -CoefW'(150);
         4'd1, 4'd14:  c = -CoefW'(250);
         4'd2, 4'd13:  c = CoefW'(0);
         4'd3, 4'd12:  c = CoefW'(800);
         4'd4, 4'd11:  c = CoefW'(1900);
         4'd5, 4'd10:  c = CoefW'(3300);
         4'd6, 4'd9:   c = CoefW'(4800);
         4'd7, 4'd8:   c = CoefW'(5900);
         default:      c = CoefW'(0);
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/pdmdec_cic.sv @@
// Bit-serial three-stage CIC decimator, one PDM bit per cycle, combs one stage a cycle.
// Depends on pdmdec_pkg.
`default_nettype none

module pdmdec_cic import pdmdec_pkg::*; (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  wire  [ByteW-1:0]         pdm_bits,
   output cic_status_type           status,
   output logic signed [SampW-1:0]  sample
);

   typedef enum logic [1:0] {CIC_IDLE, CIC_BITS, CIC_COMB} cic_state_type;

   localparam logic [CntW-1:0] DecCnt = CntW'(Decimation);

   cic_state_type          state_ff;
   logic [ByteW-1:0]       shift_ff;
   logic [2:0]             bit_idx_ff;
   logic [CntW-1:0]        count_ff;
   logic [IntW-1:0]        integ_ff [3];
   logic [IntW-1:0]        hist_ff [3];
   logic                   hit_ff;
   logic [IntW-1:0]        cap_ff;
   logic [1:0]             stage_ff;
   logic [IntW-1:0]        t_ff;
   logic                   done_ff;
   logic signed [SampW-1:0] sample_ff;

   logic [IntW-1:0] x_in, i0_in, i1_in, i2_in, diff_in;
   logic [CntW-1:0] cnt_in;
   logic            period_end;

   always_comb begin
      x_in       = shift_ff[ByteW-1] ? IntW'(1) : '1;
      i0_in      = integ_ff[0] + x_in;
      i1_in      = integ_ff[1] + i0_in;
      i2_in      = integ_ff[2] + i1_in;
      cnt_in     = count_ff + CntW'(1);
      period_end = (cnt_in >= DecCnt) || (cnt_in == '0);
      diff_in    = t_ff - hist_ff[stage_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= CIC_IDLE;
         bit_idx_ff <= '0;
         count_ff   <= '0;
         hit_ff     <= 1'b0;
         stage_ff   <= '0;
         done_ff    <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            integ_ff[i] <= '0;
            hist_ff[i]  <= '0;
         end
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            CIC_IDLE: begin
               if (start) begin
                  bit_idx_ff <= '0;
                  hit_ff     <= 1'b0;
                  state_ff   <= CIC_BITS;
               end
            end
            CIC_BITS: begin
               integ_ff[0] <= i0_in;
               integ_ff[1] <= i1_in;
               integ_ff[2] <= i2_in;
               count_ff    <= period_end ? '0 : cnt_in;
               if (period_end) begin
                  hit_ff <= 1'b1;
               end
               bit_idx_ff <= bit_idx_ff + 3'd1;
               if (bit_idx_ff == 3'd7) begin
                  if (period_end || hit_ff) begin
                     stage_ff <= '0;
                     state_ff <= CIC_COMB;
                  end else begin
                     done_ff  <= 1'b1;
                     state_ff <= CIC_IDLE;
                  end
               end
            end
            CIC_COMB: begin
               hist_ff[stage_ff] <= t_ff;
               stage_ff          <= stage_ff + 2'd1;
               if (stage_ff == 2'd2) begin
                  done_ff  <= 1'b1;
                  state_ff <= CIC_IDLE;
               end
            end
            default: state_ff <= CIC_IDLE;
         endcase
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (state_ff == CIC_IDLE && start) begin
         shift_ff <= pdm_bits;
      end else if (state_ff == CIC_BITS) begin
         shift_ff <= {shift_ff[ByteW-2:0], 1'b0};
         if (period_end) begin
            cap_ff <= i2_in;
         end
         if (bit_idx_ff == 3'd7) begin
            t_ff <= period_end ? i2_in : cap_ff;
         end
      end else if (state_ff == CIC_COMB) begin
         t_ff <= diff_in;
         if (stage_ff == 2'd2) begin
            sample_ff <= $signed(diff_in[IntW-1:CombShift]);
         end
      end
   end

   assign status.done = done_ff;
   assign status.hit  = hit_ff;
   assign sample      = sample_ff;

endmodule

`default_nettype wire

@@ rtl/core/pdmdec_fir.sv @@
// 16-tap FIR over a ring held in a synchronous memory, one tap per cycle on a shared MAC.
// Depends on pdmdec_pkg.
`default_nettype none

module pdmdec_fir import pdmdec_pkg::*; (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   input  wire  signed [SampW-1:0]   sample_in,
   output fir_status_type            status,
   output logic signed [PcmW-1:0]    pcm_sample
);

   typedef enum logic [1:0] {FIR_IDLE, FIR_ISSUE, FIR_DRAIN, FIR_SAT} fir_state_type;

   logic signed [SampW-1:0] line_mem [Taps];
   logic [Taps-1:0]         valid_ff;

   fir_state_type           state_ff;
   logic [TapIdxW-1:0]      widx_ff;
   logic [TapIdxW-1:0]      tap_ff;
   logic                    rd_pend_ff;
   logic                    prod_pend_ff;
   logic                    rd_ok_ff;
   logic [TapIdxW-1:0]      coef_idx_ff;
   logic signed [SampW-1:0] rd_data_ff;
   logic signed [ProdW-1:0] prod_ff;
   logic signed [AccW-1:0]  acc_ff;
   logic signed [PcmW-1:0]  result_ff;
   logic                    done_ff;

   logic [TapIdxW-1:0]      rd_addr;
   logic                    wr_en;
   logic signed [SampW-1:0] tap_data;
   logic signed [ProdW-1:0] prod_in;
   logic signed [AccW-1:0]  term_in;

   always_comb begin
      rd_addr  = widx_ff - tap_ff;
      wr_en    = (state_ff == FIR_IDLE) && start;
      tap_data = rd_ok_ff ? rd_data_ff : '0;
      prod_in  = tap_data * fir_coef(coef_idx_ff);
      // floor of product / 2^15
      term_in  = {{(AccW-TermW){prod_ff[ProdW-1]}}, prod_ff[ProdW-1:ProdShift]};
   end

   // ring memory, one write and one read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[widx_ff] <= sample_in;
      end
      rd_data_ff <= line_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FIR_IDLE;
         valid_ff     <= '0;
         widx_ff      <= '0;
         tap_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         prod_pend_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         done_ff      <= 1'b0;
         rd_pend_ff   <= (state_ff == FIR_ISSUE);
         prod_pend_ff <= rd_pend_ff;
         case (state_ff)
            FIR_IDLE: begin
               if (start) begin
                  valid_ff[widx_ff] <= 1'b1;
                  tap_ff            <= '0;
                  state_ff          <= FIR_ISSUE;
               end
            end
            FIR_ISSUE: begin
               tap_ff <= tap_ff + TapIdxW'(1);
               if (tap_ff == TapIdxW'(Taps - 1)) begin
                  state_ff <= FIR_DRAIN;
               end
            end
            FIR_DRAIN: begin
               if (!rd_pend_ff && !prod_pend_ff) begin
                  state_ff <= FIR_SAT;
               end
            end
            FIR_SAT: begin
               widx_ff  <= widx_ff + TapIdxW'(1);
               done_ff  <= 1'b1;
               state_ff <= FIR_IDLE;
            end
            default: state_ff <= FIR_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == FIR_ISSUE) begin
         rd_ok_ff    <= valid_ff[rd_addr];
         coef_idx_ff <= tap_ff;
      end
      if (rd_pend_ff) begin
         prod_ff <= prod_in;
      end
      if (wr_en) begin
         acc_ff <= '0;
      end else if (prod_pend_ff) begin
         acc_ff <= acc_ff + term_in;
      end
      if (state_ff == FIR_SAT) begin
         if (acc_ff > PcmMax) begin
            result_ff <= PcmW'(PcmMax);
         end else if (acc_ff < PcmMin) begin
            result_ff <= PcmW'(PcmMin);
         end else begin
            result_ff <= acc_ff[PcmW-1:0];
         end
      end
   end

   assign status.busy = (state_ff != FIR_IDLE);
   assign status.done = done_ff;
   assign pcm_sample  = result_ff;

endmodule

`default_nettype wire

@@ rtl/core/pdm_to_pcm_decimator.sv @@
// Top level of the PDM to PCM decimator: request control and output register.
// Depends on pdmdec_pkg, pdmdec_cic, pdmdec_fir and pdm_to_pcm_decimator_macros.svh.
`default_nettype none

// Each request carries one byte of PDM bits, used MSB first (1 = +1, 0 = -1). The bits run
// through a three-stage CIC integrator one bit per clock; after every 64 bits the three combs
// run one stage per clock and the result, shifted right by 3, enters a 16-tap Q15 FIR whose
// delay line sits in a 16-entry synchronous RAM. The FIR reads one tap per clock into a single
// shared multiplier and accumulator, then saturates to int16. A byte that does not close a
// decimation period runs the integrator steps and the hand-off back to idle before the next
// byte is taken; a byte that closes one also runs the three comb steps and the 16 FIR reads
// through the one RAM read port and the MAC pipeline. One PCM sample leaves per closed
// period; it waits in an output register, so further bytes are taken while the sample is
// still stalled. A second closed period holds its sample in the FIR and stalls the input
// until the output register drains.
// After reset the FIR delay line reads as zero; no clearing pass is needed.

module pdm_to_pcm_decimator import pdmdec_pkg::*; (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire  [ByteW-1:0]        req_pdm_bits,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic signed [PcmW-1:0]  rsp_pcm_sample
);

`include "pdm_to_pcm_decimator_macros.svh"

   typedef enum logic [1:0] {TOP_IDLE, TOP_CIC, TOP_FIR, TOP_HOLD} top_state_type;

   top_state_type           state_ff;
   logic                    rsp_valid_ff;
   logic signed [PcmW-1:0]  rsp_sample_ff;

   cic_status_type          cic_status;
   fir_status_type          fir_status;
   logic signed [SampW-1:0] cic_sample;
   logic signed [PcmW-1:0]  fir_pcm;

   logic req_take;
   logic fir_start;
   logic out_load;

   // one request in flight; a new byte is taken only when the core is idle
   assign req_stall = (state_ff != TOP_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign fir_start = (state_ff == TOP_CIC) && cic_status.done && cic_status.hit;
   // load a held FIR sample when the output register is empty or being drained this clock
   assign out_load  = (state_ff == TOP_HOLD) && (!rsp_valid_ff || !rsp_stall);

   pdmdec_cic u_cic (
      .clock    (clock),
      .reset    (reset),
      .start    (req_take),
      .pdm_bits (req_pdm_bits),
      .status   (cic_status),
      .sample   (cic_sample)
   );

   pdmdec_fir u_fir (
      .clock      (clock),
      .reset      (reset),
      .start      (fir_start),
      .sample_in  (cic_sample),
      .status     (fir_status),
      .pcm_sample (fir_pcm)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            TOP_IDLE: begin
               if (req_take) begin
                  state_ff <= TOP_CIC;
               end
            end
            TOP_CIC: begin
               if (cic_status.done) begin
                  state_ff <= cic_status.hit ? TOP_FIR : TOP_IDLE;
               end
            end
            TOP_FIR: begin
               if (fir_status.done) begin
                  state_ff <= TOP_HOLD;
               end
            end
            TOP_HOLD: begin
               if (out_load) begin
                  state_ff <= TOP_IDLE;
               end
            end
            default: state_ff <= TOP_IDLE;
         endcase

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sample_ff <= fir_pcm;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pcm_sample = rsp_sample_ff;

   `PDMDEC_ASSERT_NEXT(a_take_blocks, req_take, req_stall, "request taken but core not busy")
   `PDMDEC_ASSERT_IMPLY(a_fir_start_idle, fir_start, !fir_status.busy, "FIR started while busy")
   `PDMDEC_ASSERT_IMPLY(a_no_overwrite, out_load, !(rsp_valid_ff && rsp_stall), "output lost")

endmodule

`default_nettype wire
